### rtl/cmaf_pkg.sv
// ----------------------------------------------------------------------------
// cmaf_pkg: shared types and constants of the centred moving-average filter
// Widths of the sample path, history depth, job record passed from the
// front end to the back end, and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package cmaf_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int INDEX_BITS     = 16;
   localparam int HW_BITS        = 4;
   localparam int MAX_HALF       = 15;
   localparam int HIST_DEPTH     = 2 * MAX_HALF + 1;
   localparam int SLOT_BITS      = $clog2(HIST_DEPTH);
   localparam int SUM_BITS       = 21;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS    = QPTR_BITS + 1;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_WIDTH   = 2'd1;

   // One accepted sample as seen by the back end.
   typedef struct packed {
      logic                        emit;      // sample releases results
      logic                        interior;  // first result is a window mean
      logic                        eof;       // run closes the frame
      logic [SLOT_BITS-1:0]        slot;      // history slot of first index
      logic [HW_BITS-1:0]          cnt_m1;    // results in the run, minus one
      logic signed [SUM_BITS-1:0]  sum;       // window sum after this sample
   } job_type;

endpackage

`default_nettype wire

### rtl/cmaf_ram.sv
// ----------------------------------------------------------------------------
// cmaf_ram: generic RAM, one write port, two registered read ports
// Reads return the contents before a write to the same address in the cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cmaf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 31,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_a_en,
   input  logic [ADDR_BITS-1:0] rd_a_addr,
   output logic [WIDTH-1:0]     rd_a_data,
   input  logic                 rd_b_en,
   input  logic [ADDR_BITS-1:0] rd_b_addr,
   output logic [WIDTH-1:0]     rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_data_ff;
   logic [WIDTH-1:0] rd_b_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_data_ff <= mem_ff[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_data_ff <= mem_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

`default_nettype wire

### rtl/cmaf_front.sv
// ----------------------------------------------------------------------------
// cmaf_front: sample intake, running window sum and job classification
// Stage A takes a sample, stores it and fetches the sample leaving the
// window; stage B updates the window sum and pushes one job per sample.
// ----------------------------------------------------------------------------
`default_nettype none

module cmaf_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [cmaf_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic [cmaf_pkg::INDEX_BITS-1:0]         frame_length,
   input  logic [cmaf_pkg::HW_BITS-1:0]            half_width,
   input  logic                                    restart,
   input  logic [cmaf_pkg::QCOUNT_BITS-1:0]        q_count,
   output logic                                    hist_wr_en,
   output logic [cmaf_pkg::SLOT_BITS-1:0]          hist_wr_addr,
   output logic [cmaf_pkg::SAMPLE_BITS-1:0]        hist_wr_data,
   output logic                                    hist_rd_en,
   output logic [cmaf_pkg::SLOT_BITS-1:0]          hist_rd_addr,
   input  logic [cmaf_pkg::SAMPLE_BITS-1:0]        hist_rd_data,
   output logic                                    job_push,
   output cmaf_pkg::job_type                       job
);

   import cmaf_pkg::*;

   localparam int IDX1_BITS = INDEX_BITS + 1;
   localparam int TAP_BITS  = HW_BITS + 1;

   logic [INDEX_BITS-1:0]      count_ff, count_in;
   logic [SLOT_BITS-1:0]       wptr_ff, wptr_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic                       b_valid_ff, b_valid_in;
   logic signed [SAMPLE_BITS-1:0] b_x_ff;
   logic                       b_sub_ff;
   logic                       b_last_ff;
   job_type                    b_job_ff;

   logic                       accept;
   logic [IDX1_BITS-1:0]       n_plus;
   logic                       last;
   logic                       hw_reached;
   logic [TAP_BITS-1:0]        taps;
   logic                       sub;
   logic [HW_BITS-1:0]         off;
   logic [INDEX_BITS-1:0]      jstart;
   logic                       interior;
   logic [SLOT_BITS-1:0]       slot;
   logic [SLOT_BITS-1:0]       sub_addr;
   job_type                    a_job;
   logic signed [SUM_BITS-1:0] leaving;
   logic signed [SUM_BITS-1:0] sum_new;

   assign req_stall = (q_count + QCOUNT_BITS'(b_valid_ff)) >= QCOUNT_BITS'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   // classify the incoming sample
   always_comb begin
      n_plus     = {1'b0, count_ff} + IDX1_BITS'(1);
      last       = n_plus >= {1'b0, frame_length};
      hw_reached = count_ff >= INDEX_BITS'(half_width);
      taps       = {half_width, 1'b1};
      sub        = count_ff >= INDEX_BITS'(taps);
      off        = hw_reached ? half_width : count_ff[HW_BITS-1:0];
      jstart     = count_ff - INDEX_BITS'(off);
      interior   = (jstart >= INDEX_BITS'(half_width)) &&
                   (({1'b0, jstart} + IDX1_BITS'(half_width) + IDX1_BITS'(1))
                    <= {1'b0, frame_length});

      if (wptr_ff >= SLOT_BITS'(off)) begin
         slot = wptr_ff - SLOT_BITS'(off);
      end else begin
         slot = wptr_ff + SLOT_BITS'(HIST_DEPTH) - SLOT_BITS'(off);
      end
      if (wptr_ff >= SLOT_BITS'(taps)) begin
         sub_addr = wptr_ff - SLOT_BITS'(taps);
      end else begin
         sub_addr = wptr_ff + SLOT_BITS'(HIST_DEPTH) - SLOT_BITS'(taps);
      end

      a_job          = '0;
      a_job.emit     = last || hw_reached;
      a_job.interior = interior;
      a_job.eof      = last;
      a_job.slot     = slot;
      a_job.cnt_m1   = last ? off : '0;
   end

   // window sum update in stage B
   always_comb begin
      leaving = b_sub_ff ? SUM_BITS'($signed(hist_rd_data)) : '0;
      sum_new = sum_ff + SUM_BITS'(b_x_ff) - leaving;
      job     = b_job_ff;
      job.sum = sum_new;
   end

   assign job_push     = b_valid_ff;
   assign hist_wr_en   = accept;
   assign hist_wr_addr = wptr_ff;
   assign hist_wr_data = req_sample;
   assign hist_rd_en   = accept;
   assign hist_rd_addr = sub_addr;

   always_comb begin
      count_in   = count_ff;
      wptr_in    = wptr_ff;
      sum_in     = sum_ff;
      b_valid_in = accept;
      if (accept) begin
         count_in = last ? '0 : n_plus[INDEX_BITS-1:0];
         wptr_in  = (wptr_ff == SLOT_BITS'(HIST_DEPTH - 1)) ? '0 : wptr_ff + SLOT_BITS'(1);
      end
      if (b_valid_ff) begin
         sum_in = b_last_ff ? '0 : sum_new;
      end
      if (restart) begin
         count_in = '0;
         sum_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         wptr_ff    <= '0;
         sum_ff     <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         wptr_ff    <= wptr_in;
         sum_ff     <= sum_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_x_ff    <= req_sample;
         b_sub_ff  <= sub;
         b_last_ff <= last;
         b_job_ff  <= a_job;
      end
   end

endmodule

`default_nettype wire

### rtl/cmaf_queue.sv
// ----------------------------------------------------------------------------
// cmaf_queue: short job queue between front end and back end
// First-in first-out register queue; the producer never pushes when full.
// ----------------------------------------------------------------------------
`default_nettype none

module cmaf_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  cmaf_pkg::job_type                push_job,
   input  logic                             pop,
   output logic                             head_valid,
   output cmaf_pkg::job_type                head_job,
   output logic [cmaf_pkg::QCOUNT_BITS-1:0] count
);

   import cmaf_pkg::*;

   job_type                mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QCOUNT_BITS'(push) - QCOUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_valid = count_ff != '0;
   assign head_job   = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

`default_nettype wire

### rtl/cmaf_back.sv
// ----------------------------------------------------------------------------
// cmaf_back: result sequencer, divider and output register
// Issues one result a clock from the head job unless the output stalls,
// divides the window sum by tap count via reciprocal multiply, registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module cmaf_back (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [cmaf_pkg::HW_BITS-1:0]             half_width,
   input  logic                                     head_valid,
   input  cmaf_pkg::job_type                        head_job,
   output logic                                     pop,
   output logic                                     hist_rd_en,
   output logic [cmaf_pkg::SLOT_BITS-1:0]           hist_rd_addr,
   input  logic [cmaf_pkg::SAMPLE_BITS-1:0]         hist_rd_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [cmaf_pkg::SAMPLE_BITS-1:0]  rsp_filtered,
   output logic                                     rsp_last_of_run,
   output logic                                     rsp_end_of_frame
);

   import cmaf_pkg::*;

   localparam int MAG_BITS    = SUM_BITS - 1;
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP_BITS  = RECIP_SHIFT + 1;
   localparam int PROD_BITS   = MAG_BITS + RECIP_BITS;
   localparam int ADDR6_BITS  = SLOT_BITS + 1;

   // ceil(2^26 / (2*hw+1)); exact quotient for every window sum magnitude
   localparam logic [RECIP_BITS-1:0] RECIP_TABLE [16] = '{
      27'd67108864, 27'd22369622, 27'd13421773, 27'd9586981,
      27'd7456541,  27'd6100806,  27'd5162221,  27'd4473925,
      27'd3947581,  27'd3532046,  27'd3195661,  27'd2917777,
      27'd2684355,  27'd2485514,  27'd2314099,  27'd2164803
   };

   logic [HW_BITS-1:0]         k_ff, k_in;
   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_div_ff, s1_neg_ff, s1_last_ff, s1_eof_ff;
   logic [MAG_BITS-1:0]        s1_mag_ff;
   logic                       s2_valid_ff, s2_valid_in;
   logic                       s2_div_ff, s2_neg_ff, s2_last_ff, s2_eof_ff;
   logic [PROD_BITS-1:0]       s2_prod_ff;
   logic [SAMPLE_BITS-1:0]     s2_hist_ff;
   logic                       out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0]     out_value_ff, out_value_in;
   logic                       out_last_ff, out_eof_ff;

   logic                       advance;
   logic                       issue;
   logic                       run_end;
   logic [ADDR6_BITS-1:0]      addr_sum;
   logic signed [SUM_BITS-1:0] mag_full;
   logic [PROD_BITS-1:0]       prod_in;
   logic [SAMPLE_BITS-1:0]     quo;

   // whole pipeline moves whenever the output register can take a value
   assign advance = !out_valid_ff || !rsp_stall;
   assign issue   = advance && head_valid;
   assign run_end = !head_job.emit || (k_ff == head_job.cnt_m1);
   assign pop     = issue && run_end;

   always_comb begin
      addr_sum = {1'b0, head_job.slot} + ADDR6_BITS'(k_ff);
      if (addr_sum >= ADDR6_BITS'(HIST_DEPTH)) begin
         addr_sum = addr_sum - ADDR6_BITS'(HIST_DEPTH);
      end
      hist_rd_addr = addr_sum[SLOT_BITS-1:0];
      hist_rd_en   = advance;

      mag_full = head_job.sum[SUM_BITS-1] ? -head_job.sum : head_job.sum;

      k_in = k_ff;
      if (issue) begin
         k_in = run_end ? '0 : k_ff + HW_BITS'(1);
      end

      s1_valid_in  = issue && head_job.emit;
      s2_valid_in  = s1_valid_ff;
      out_valid_in = s2_valid_ff;

      prod_in = PROD_BITS'(s1_mag_ff) * PROD_BITS'(RECIP_TABLE[half_width]);

      quo          = s2_prod_ff[RECIP_SHIFT +: SAMPLE_BITS];
      out_value_in = s2_hist_ff;
      if (s2_div_ff) begin
         out_value_in = s2_neg_ff ? -quo : quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         k_ff <= k_in;
         if (advance) begin
            s1_valid_ff  <= s1_valid_in;
            s2_valid_ff  <= s2_valid_in;
            out_valid_ff <= out_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_div_ff    <= (k_ff == '0) && head_job.interior;
         s1_neg_ff    <= head_job.sum[SUM_BITS-1];
         s1_mag_ff    <= mag_full[MAG_BITS-1:0];
         s1_last_ff   <= run_end;
         s1_eof_ff    <= head_job.eof && run_end;
         s2_div_ff    <= s1_div_ff;
         s2_neg_ff    <= s1_neg_ff;
         s2_last_ff   <= s1_last_ff;
         s2_eof_ff    <= s1_eof_ff;
         s2_prod_ff   <= prod_in;
         s2_hist_ff   <= hist_rd_data;
         out_value_ff <= out_value_in;
         out_last_ff  <= s2_last_ff;
         out_eof_ff   <= s2_eof_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_filtered     = out_value_ff;
   assign rsp_last_of_run  = out_last_ff;
   assign rsp_end_of_frame = out_eof_ff;

endmodule

`default_nettype wire

### rtl/centered_moving_average_filter.sv
// ----------------------------------------------------------------------------
// centered_moving_average_filter: centred boxcar smoother for Q4.12 frames
// Top level: configuration registers, history RAM, front end, job queue and
// back end.
// ----------------------------------------------------------------------------
// Smooths frames of signed Q4.12 samples with a centred window of
// 2*half_width+1 taps; samples within half_width of either frame edge pass
// through unchanged, interior samples become the window mean truncated
// toward zero. The result for index i leaves once sample i+half_width has
// been taken, and the frame's last sample also releases the trailing edge
// samples, so that sample causes min(index, half_width)+1 results. A sample
// is taken in any clock in which the four-entry job queue has room; while
// the receiver does not stall, the back end issues one result per clock, so
// within a frame the block sustains one sample per clock, and at the end of
// a frame the back end also issues the trailing edge results. The history
// RAM needs no clearing pass: only samples of the current frame are ever
// read. Writing either configuration register aborts the frame in progress;
// write only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module centered_moving_average_filter (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [cmaf_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [cmaf_pkg::SAMPLE_BITS-1:0] rsp_filtered,
   output logic                                    rsp_last_of_run,
   output logic                                    rsp_end_of_frame,
   input  logic                                    csr_write_enable,
   input  logic [cmaf_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [cmaf_pkg::INDEX_BITS-1:0]         csr_write_data
);

   import cmaf_pkg::*;

   // configuration registers
   logic [INDEX_BITS-1:0]  frame_length_ff, frame_length_in;
   logic [HW_BITS-1:0]     half_width_ff, half_width_in;
   logic                   restart;

   // history RAM ports
   logic                   hist_wr_en;
   logic [SLOT_BITS-1:0]   hist_wr_addr;
   logic [SAMPLE_BITS-1:0] hist_wr_data;
   logic                   hist_a_en;
   logic [SLOT_BITS-1:0]   hist_a_addr;
   logic [SAMPLE_BITS-1:0] hist_a_data;
   logic                   hist_b_en;
   logic [SLOT_BITS-1:0]   hist_b_addr;
   logic [SAMPLE_BITS-1:0] hist_b_data;

   // job queue
   logic                   q_push;
   job_type                q_push_job;
   logic                   q_pop;
   logic                   q_head_valid;
   job_type                q_head_job;
   logic [QCOUNT_BITS-1:0] q_count;

   // Take a register write at once; either register restarts the frame.
   always_comb begin
      frame_length_in = frame_length_ff;
      half_width_in   = half_width_ff;
      restart         = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_LENGTH: begin
               frame_length_in = csr_write_data;
               restart         = 1'b1;
            end
            CSR_HALF_WIDTH: begin
               half_width_in = csr_write_data[HW_BITS-1:0];
               restart       = 1'b1;
            end
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= INDEX_BITS'(1024);
         half_width_ff   <= HW_BITS'(1);
      end else begin
         frame_length_ff <= frame_length_in;
         half_width_ff   <= half_width_in;
      end
   end

   // Port A serves the sample leaving the window, port B the edge samples.
   cmaf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (HIST_DEPTH)
   ) u_hist (
      .clock     (clock),
      .wr_en     (hist_wr_en),
      .wr_addr   (hist_wr_addr),
      .wr_data   (hist_wr_data),
      .rd_a_en   (hist_a_en),
      .rd_a_addr (hist_a_addr),
      .rd_a_data (hist_a_data),
      .rd_b_en   (hist_b_en),
      .rd_b_addr (hist_b_addr),
      .rd_b_data (hist_b_data)
   );

   // Front end: one job per sample, including samples that release nothing,
   // so the queue also bounds how far the writer runs ahead of the reader.
   cmaf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .frame_length (frame_length_ff),
      .half_width   (half_width_ff),
      .restart      (restart),
      .q_count      (q_count),
      .hist_wr_en   (hist_wr_en),
      .hist_wr_addr (hist_wr_addr),
      .hist_wr_data (hist_wr_data),
      .hist_rd_en   (hist_a_en),
      .hist_rd_addr (hist_a_addr),
      .hist_rd_data (hist_a_data),
      .job_push     (q_push),
      .job          (q_push_job)
   );

   cmaf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_push_job),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_job   (q_head_job),
      .count      (q_count)
   );

   // Back end: hold the output register while the receiver stalls.
   cmaf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .half_width       (half_width_ff),
      .head_valid       (q_head_valid),
      .head_job         (q_head_job),
      .pop              (q_pop),
      .hist_rd_en       (hist_b_en),
      .hist_rd_addr     (hist_b_addr),
      .hist_rd_data     (hist_b_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_filtered     (rsp_filtered),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

`ifndef SYNTHESIS
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count != QCOUNT_BITS'(QUEUE_DEPTH)))
      else $error("job pushed into a full queue");

   a_queue_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_count != '0))
      else $error("job popped from an empty queue");

   // A mid-frame window mean stands alone; only the closing sample adds edges.
   a_interior_single: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_push_job.interior && q_push_job.emit && !q_push_job.eof)
      |-> (q_push_job.cnt_m1 == '0))
      else $error("window mean job with more than one result");

   a_eof_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_frame) |-> rsp_last_of_run)
      else $error("frame end not on the final transfer of a run");
`endif

endmodule

`default_nettype wire
